// ----- design/csc_pkg.sv -----
package csc_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int SAMPLE_W   = 8;
    localparam int HSUM_W     = 10;
    localparam int LINE_W     = 9;

    typedef enum logic [1:0] {
        FMT_420 = 2'd0,
        FMT_411 = 2'd1,
        FMT_422 = 2'd2,
        FMT_444 = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        CFG_SRC_FMT = 2'd0,
        CFG_DST_FMT = 2'd1,
        CFG_WIDTH   = 2'd2,
        CFG_HEIGHT  = 2'd3
    } cfg_idx_t;

    // Placement of the results of one source sample around a base position.
    typedef enum logic [2:0] {
        PAT_ONE   = 3'd0,
        PAT_VPAIR = 3'd1,
        PAT_HPAIR = 3'd2,
        PAT_QUAD  = 3'd3,
        PAT_HQUAD = 3'd4
    } pat_t;

    // Where the value of a result comes from.
    typedef enum logic [2:0] {
        VAL_SAMPLE  = 3'd0,
        VAL_HALF_H  = 3'd1,
        VAL_QUART_H = 3'd2,
        VAL_VAVG2   = 3'd3,
        VAL_VAVG4   = 3'd4
    } val_t;

    function automatic logic [1:0] pat_last(input pat_t p);
        logic [1:0] r;
        r = 2'd0;
        case (p)
            PAT_ONE:   r = 2'd0;
            PAT_VPAIR: r = 2'd1;
            PAT_HPAIR: r = 2'd1;
            PAT_QUAD:  r = 2'd3;
            PAT_HQUAD: r = 2'd3;
            default:   r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/chroma_subsampling_converter_core.sv -----
// Chroma subsampling converter: resamples one chroma plane between the
// 4:2:0, 4:1:1, 4:2:2 and 4:4:4 layouts.
// Source bytes enter on the s_axis stream in raster order; the block keeps
// the source row and column itself. Each destination byte leaves on the
// m_axis stream with its destination row and column, and tlast marks the
// final result caused by one source byte. Some source bytes cause no result.
// The cfg channel writes the formats and the luma picture size; it is always
// ready and must only be used while no transaction is in flight.
// An accepted source byte is registered as an expansion job, and each of
// its results (1, 2 or 4) then passes one at a time through the single
// result register; the next byte is taken along with the last result of
// the job, so the input takes one byte per cycle for one-to-one and
// downsampling mappings while the receiver does not stall.
// Vertical averages use a 2048 x 9 bit line buffer in a synchronous RAM,
// written on even source rows and read on the following odd row.
// Reset clears the position, the partial sum and the configuration (4:2:0
// to 4:2:0, 720 x 576); the line buffer is not cleared.
// When the receiver stalls, the pending result holds, the expansion of the
// current byte pauses, and s_axis_tready drops once that byte is not done.
module chroma_subsampling_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] value, [19:8] dest_row, [31:20] dest_col
    output logic        m_axis_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import csc_pkg::*;

    // Configuration registers.
    fmt_t              src_fmt_reg;
    fmt_t              dst_fmt_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;

    // Stream position and horizontal partial sum.
    logic [POS_W-1:0]  col_reg,  col_next;
    logic [POS_W-1:0]  row_reg,  row_next;
    logic [HSUM_W-1:0] hsum_reg, hsum_next;

    // Line buffer.
    logic [LINE_W-1:0] line_mem [LINE_DEPTH];
    logic [LINE_W-1:0] line_rd_reg;

    // Expansion job for the accepted source byte.
    logic               job_valid_reg;
    pat_t               job_pat_reg;
    val_t               job_kind_reg;
    logic [POS_W-1:0]   job_row_reg;
    logic [POS_W-1:0]   job_col_reg;
    logic [SAMPLE_W-1:0] job_v_reg;
    logic [HSUM_W-1:0]  job_hsum_reg;
    logic               job_zero_reg;
    logic [1:0]         job_k_reg;

    // Result register.
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic               out_last_reg;

    logic               in_accept;
    logic               emit;
    logic               job_done;
    logic [1:0]         last_k;

    logic [DIM_W-1:0]   w_cl, h_cl, src_w, src_h;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic [SAMPLE_W-1:0] v;
    logic               has_out;
    pat_t               pat;
    val_t               kind;
    logic [POS_W-1:0]   base_row, base_col;
    logic [POS_W-1:0]   line_idx;
    logic               line_we;
    logic [LINE_W-1:0]  line_wdata;

    logic [POS_W-1:0]   res_row, res_col;
    logic [SAMPLE_W-1:0] res_val;
    logic [LINE_W-1:0]  line_val;
    logic [HSUM_W-1:0]  vavg2_sum;
    logic [HSUM_W:0]    vavg4_sum;

    assign cfg_ready = 1'b1;
    assign v         = s_axis_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= FMT_420;
            dst_fmt_reg <= FMT_420;
            width_reg   <= 13'd720;
            height_reg  <= 13'd576;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SRC_FMT: src_fmt_reg <= fmt_t'(cfg_data[1:0]);
                CFG_DST_FMT: dst_fmt_reg <= fmt_t'(cfg_data[1:0]);
                CFG_WIDTH:   width_reg   <= cfg_data;
                CFG_HEIGHT:  height_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Source plane size from the clamped luma size.
    always_comb
    begin
        w_cl = (width_reg  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : width_reg;
        h_cl = (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
        case (src_fmt_reg)
            FMT_444: src_w = w_cl;
            FMT_411: src_w = w_cl >> 2;
            default: src_w = w_cl >> 1;
        endcase
        src_h   = (src_fmt_reg == FMT_420) ? (h_cl >> 1) : h_cl;
        col_inc = {1'b0, col_reg} + 13'd1;
        row_inc = {1'b0, row_reg} + 13'd1;
    end

    // Mapping decode for the byte at the input.
    always_comb
    begin
        has_out    = 1'b0;
        pat        = PAT_ONE;
        kind       = VAL_SAMPLE;
        base_row   = row_reg;
        base_col   = col_reg;
        line_idx   = col_reg;
        line_we    = 1'b0;
        line_wdata = {1'b0, v};
        hsum_next  = hsum_reg;

        // Horizontal partial sum over groups of two or four source columns.
        if ((src_fmt_reg == FMT_420 && dst_fmt_reg == FMT_411) ||
            (src_fmt_reg == FMT_422 && dst_fmt_reg == FMT_411) ||
            (src_fmt_reg == FMT_444 && dst_fmt_reg == FMT_420) ||
            (src_fmt_reg == FMT_444 && dst_fmt_reg == FMT_422))
        begin
            hsum_next = (col_reg[0] == 1'b0) ? HSUM_W'(v) : hsum_reg + HSUM_W'(v);
        end
        else if (src_fmt_reg == FMT_444 && dst_fmt_reg == FMT_411)
        begin
            hsum_next = (col_reg[1:0] == 2'd0) ? HSUM_W'(v) : hsum_reg + HSUM_W'(v);
        end

        if (src_fmt_reg == dst_fmt_reg)
        begin
            has_out = 1'b1;
        end
        else if (src_fmt_reg == FMT_420)
        begin
            base_row = {row_reg[POS_W-2:0], 1'b0};
            case (dst_fmt_reg)
                FMT_411:
                begin
                    has_out  = col_reg[0];
                    pat      = PAT_VPAIR;
                    kind     = VAL_HALF_H;
                    base_col = col_reg >> 1;
                end
                FMT_422:
                begin
                    has_out = 1'b1;
                    pat     = PAT_VPAIR;
                end
                default:
                begin
                    has_out  = 1'b1;
                    pat      = PAT_QUAD;
                    base_col = {col_reg[POS_W-2:0], 1'b0};
                end
            endcase
        end
        else if (src_fmt_reg == FMT_411 || src_fmt_reg == FMT_422)
        begin
            if (dst_fmt_reg == FMT_420)
            begin
                line_idx = col_reg;
                if (row_reg[0] == 1'b0)
                begin
                    line_we = 1'b1;
                end
                else
                begin
                    has_out  = 1'b1;
                    kind     = VAL_VAVG2;
                    base_row = row_reg >> 1;
                    if (src_fmt_reg == FMT_411)
                    begin
                        pat      = PAT_HPAIR;
                        base_col = {col_reg[POS_W-2:0], 1'b0};
                    end
                end
            end
            else if (src_fmt_reg == FMT_422 && dst_fmt_reg == FMT_411)
            begin
                has_out  = col_reg[0];
                kind     = VAL_HALF_H;
                base_col = col_reg >> 1;
            end
            else if (src_fmt_reg == FMT_411 && dst_fmt_reg == FMT_444)
            begin
                has_out  = 1'b1;
                pat      = PAT_HQUAD;
                base_col = {col_reg[POS_W-3:0], 2'b00};
            end
            else
            begin
                // Twofold horizontal duplication.
                has_out  = 1'b1;
                pat      = PAT_HPAIR;
                base_col = {col_reg[POS_W-2:0], 1'b0};
            end
        end
        else
        begin
            case (dst_fmt_reg)
                FMT_420:
                begin
                    line_idx   = col_reg >> 1;
                    line_wdata = hsum_next[LINE_W-1:0];
                    base_row   = row_reg >> 1;
                    base_col   = col_reg >> 1;
                    kind       = VAL_VAVG4;
                    if (col_reg[0])
                    begin
                        if (row_reg[0] == 1'b0)
                        begin
                            line_we = 1'b1;
                        end
                        else
                        begin
                            has_out = 1'b1;
                        end
                    end
                end
                FMT_411:
                begin
                    has_out  = (col_reg[1:0] == 2'd3);
                    kind     = VAL_QUART_H;
                    base_col = col_reg >> 2;
                end
                default:
                begin
                    has_out  = col_reg[0];
                    kind     = VAL_HALF_H;
                    base_col = col_reg >> 1;
                end
            endcase
        end
    end

    // Position advance in raster order.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= src_w)
        begin
            col_next = '0;
            row_next = (row_inc >= src_h) ? '0 : row_inc[POS_W-1:0];
        end
        else
        begin
            col_next = col_inc[POS_W-1:0];
        end
    end

    assign last_k        = pat_last(job_pat_reg);
    assign emit          = job_valid_reg && (!out_valid_reg || m_axis_tready);
    assign job_done      = emit && (job_k_reg == last_k);
    assign s_axis_tready = !job_valid_reg || job_done;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            hsum_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            hsum_reg <= hsum_next;
        end
    end

    // Line buffer port. An entry is written and read by different source
    // rows, so the write of one transaction always lands before any read of
    // a later one; indexes past the buffer are dropped and read as zero.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (line_we && !line_idx[POS_W-1])
            begin
                line_mem[line_idx[LINE_AW-1:0]] <= line_wdata;
            end
            line_rd_reg <= line_mem[line_idx[LINE_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_k_reg     <= '0;
        end
        else if (in_accept)
        begin
            job_valid_reg <= has_out;
            job_k_reg     <= '0;
        end
        else if (job_done)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            job_k_reg <= job_k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            job_pat_reg  <= pat;
            job_kind_reg <= kind;
            job_row_reg  <= base_row;
            job_col_reg  <= base_col;
            job_v_reg    <= v;
            job_hsum_reg <= hsum_next;
            job_zero_reg <= line_idx[POS_W-1];
        end
    end

    // Value and position of the current result of the job.
    always_comb
    begin
        line_val  = job_zero_reg ? '0 : line_rd_reg;
        vavg2_sum = HSUM_W'(line_val) + HSUM_W'(job_v_reg);
        vavg4_sum = (HSUM_W+1)'(line_val) + (HSUM_W+1)'(job_hsum_reg);
        case (job_kind_reg)
            VAL_SAMPLE:  res_val = job_v_reg;
            VAL_HALF_H:  res_val = job_hsum_reg[8:1];
            VAL_QUART_H: res_val = job_hsum_reg[9:2];
            VAL_VAVG2:   res_val = vavg2_sum[8:1];
            VAL_VAVG4:   res_val = vavg4_sum[9:2];
            default:     res_val = job_v_reg;
        endcase

        res_row = job_row_reg;
        res_col = job_col_reg;
        case (job_pat_reg)
            PAT_ONE:   ;
            PAT_VPAIR: res_row = job_row_reg + POS_W'(job_k_reg[0]);
            PAT_HPAIR: res_col = job_col_reg + POS_W'(job_k_reg[0]);
            PAT_QUAD:
            begin
                res_row = job_row_reg + POS_W'(job_k_reg[1]);
                res_col = job_col_reg + POS_W'(job_k_reg[0]);
            end
            PAT_HQUAD: res_col = job_col_reg + POS_W'(job_k_reg);
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {res_col, res_row, res_val};
            out_last_reg <= job_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // The expansion index never runs past the last result of its pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_k_reg <= last_k))
        else $error("result index beyond pattern");

    // A source byte that yields results starts a job at its first result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && has_out) |=> (job_valid_reg && job_k_reg == 2'd0))
        else $error("job not started");

    // The final result of a job carries tlast.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_done |=> (m_axis_tvalid && m_axis_tlast))
        else $error("missing tlast on final result");
`endif

endmodule
